// ===== hw/rtl/fpd_pkg.sv =====
package fpd_pkg;

	// Longest payload that a length byte may announce.
	localparam int unsigned MAX_PAYLOAD = 16;

	// Width of the length and index registers, enough to hold MAX_PAYLOAD.
	localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);

	localparam logic [7:0] HDR_FIRST  = 8'hFF;
	localparam logic [7:0] HDR_SECOND = 8'hAA;
	localparam logic [7:0] MAX_VICTIM = 8'h03;
	localparam logic [7:0] MAX_CAMERA = 8'h01;
	localparam logic [7:0] MAX_LEN_B  = 8'(MAX_PAYLOAD);
	localparam logic [LEN_W-1:0] GOOD_LEN = LEN_W'(2);

	typedef enum logic [2:0] {
		PH_HUNT0,
		PH_HUNT1,
		PH_LENGTH,
		PH_PAYLOAD,
		PH_CHECK
	} phase_t;

	typedef logic [2:0] status_t;

	localparam status_t ST_ACCEPTED   = 3'd0;
	localparam status_t ST_BAD_SUM    = 3'd1;
	localparam status_t ST_BAD_LENGTH = 3'd2;
	localparam status_t ST_BAD_CAMERA = 3'd3;
	localparam status_t ST_BAD_VICTIM = 3'd4;

	typedef struct packed {
		status_t     status;
		logic        camera;
		logic [1:0]  victim;
		logic [31:0] accepted_count;
	} result_t;

endpackage

// ===== hw/rtl/fpd_if.sv =====
interface fpd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface fpd_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        camera;
	logic [1:0]  victim;
	logic [31:0] accepted_count;

	modport source (output valid, output status, output camera, output victim,
		output accepted_count, input ready);
	modport sink (input valid, input status, input camera, input victim,
		input accepted_count, output ready);
endinterface

// ===== hw/rtl/fpd_in_stage.sv =====
module fpd_in_stage
	import fpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	fpd_byte_if.sink    rx,
	input  logic        advance,
	output logic        valid_s1,
	output logic [7:0]  byte_s1
);

	logic take;

	// The held beat leaves when the parser consumes it, so a new one may enter at once.
	assign rx.ready = !valid_s1 || advance;
	assign take     = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= rx.rx_byte;
		end
	end

endmodule

// ===== hw/rtl/fpd_parser.sv =====
module fpd_parser
	import fpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	output result_t    res
);

	phase_t            phase_q, phase_next;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  idx_q;
	logic [LEN_W-1:0]  idx_inc;
	logic [7:0]        sum_q;
	logic [7:0]        sum_next;
	logic [7:0]        head_q [2];
	logic              cam_q;
	logic [1:0]        vic_q;
	logic [31:0]       total_q;
	logic              accept;
	logic              bad_len_byte;

	assign idx_inc      = idx_q + LEN_W'(1);
	assign sum_next     = sum_q + rx_byte;
	assign bad_len_byte = !(rx_byte inside {[8'd1:MAX_LEN_B]});

	always_comb begin
		phase_next = phase_q;
		case (phase_q)
			PH_HUNT0: begin
				if (rx_byte == HDR_FIRST) begin
					phase_next = PH_HUNT1;
				end
			end
			PH_HUNT1: begin
				phase_next = (rx_byte == HDR_SECOND) ? PH_LENGTH : PH_HUNT0;
			end
			PH_LENGTH: begin
				phase_next = bad_len_byte ? PH_HUNT0 : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				if (idx_inc >= len_q) begin
					phase_next = PH_CHECK;
				end
			end
			default: begin
				phase_next = PH_HUNT0;
			end
		endcase
	end

	// The first failing test decides the status.
	always_comb begin
		accept         = 1'b0;
		res_valid      = (phase_q == PH_CHECK);
		res.status     = ST_ACCEPTED;
		if (rx_byte != sum_q) begin
			res.status = ST_BAD_SUM;
		end else if (len_q != GOOD_LEN) begin
			res.status = ST_BAD_LENGTH;
		end else if (head_q[0] > MAX_CAMERA) begin
			res.status = ST_BAD_CAMERA;
		end else if (head_q[1] > MAX_VICTIM) begin
			res.status = ST_BAD_VICTIM;
		end else begin
			accept = 1'b1;
		end
		res.camera         = accept ? head_q[0][0] : cam_q;
		res.victim         = accept ? head_q[1][1:0] : vic_q;
		res.accepted_count = accept ? total_q + 32'd1 : total_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT0;
			len_q   <= '0;
			idx_q   <= '0;
			sum_q   <= '0;
			cam_q   <= 1'b0;
			vic_q   <= '0;
			total_q <= '0;
		end else if (step) begin
			phase_q <= phase_next;
			if (phase_q == PH_LENGTH) begin
				len_q <= LEN_W'(rx_byte);
				idx_q <= '0;
				sum_q <= rx_byte;
			end
			if (phase_q == PH_PAYLOAD) begin
				idx_q <= idx_inc;
				sum_q <= sum_next;
			end
			if (res_valid && accept) begin
				cam_q   <= res.camera;
				vic_q   <= res.victim;
				total_q <= res.accepted_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && phase_q == PH_PAYLOAD && idx_q[LEN_W-1:1] == '0) begin
			head_q[idx_q[0]] <= rx_byte;
		end
	end

endmodule

// ===== hw/rtl/fpd_out_stage.sv =====
module fpd_out_stage
	import fpd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  result_t      res,
	output logic         free,
	fpd_result_if.source out
);

	logic    valid_q;
	result_t res_q;

	assign free = !valid_q || out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

	assign out.valid          = valid_q;
	assign out.status         = res_q.status;
	assign out.camera         = res_q.camera;
	assign out.victim         = res_q.victim;
	assign out.accepted_count = res_q.accepted_count;

endmodule

// ===== hw/rtl/framed_packet_deframer.sv =====
// Framed packet deframer.
// The rx channel carries one received serial byte per beat. The block hunts
// for the header bytes FF AA, reads a length byte (zero or above the largest
// payload restarts the hunt silently), takes that many payload bytes and then
// a checksum byte. Only the checksum byte produces a beat on the res channel:
// a status, the last accepted camera and victim codes and the count of
// accepted packets, which wraps at 2^32.
// Throughput is one byte per cycle while the result register is free. A byte is
// first held in an input register and then parsed into the result register, so
// a result reaches res only after it has passed through both registers.
// The parser advances only when the result register can take a new result; if
// the receiver stalls, the result is held, the parser waits on the held byte
// and rx.ready falls once the input register is full. Nothing is dropped.
// Reset returns the parser to hunting for the first header byte and clears the
// kept camera, victim and packet count; both stages come out of reset empty.
module framed_packet_deframer
	import fpd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	fpd_byte_if.sink      rx,
	fpd_result_if.source  res
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       advance;
	logic       parse_valid;
	result_t    parse_res;

	// The parser moves on whenever a byte is held and the result register is free.
	assign advance = valid_s1 && out_free;

	fpd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	fpd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.rx_byte   (byte_s1),
		.res_valid (parse_valid),
		.res       (parse_res)
	);

	fpd_out_stage u_out_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && parse_valid),
		.res    (parse_res),
		.free   (out_free),
		.out    (res)
	);

endmodule
